/* hdl/spc_pkg.sv */
// Shared constants, register map and configuration type for the SPC statistics monitor.
package spc_pkg;

  // Default parameter values
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int RUN_BITS_DEF    = 16;

  // Fixed field widths
  localparam int SUM_BITS   = 48;
  localparam int SQ_BITS    = 64;
  localparam int LIMIT_BITS = 16;
  localparam int EN_BITS    = 6;
  localparam int DIR_BITS   = 2;
  localparam int ALARM_BITS = 3;

  // APB register map, one word per register
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_UPPER    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LOWER    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_TREND    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_TRIGGER  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CROWDING = 3'd5;

  // Control limit reset codes, taken to the sample width
  localparam logic [31:0] UPPER_RST = 32'h0000_7FFF;
  localparam logic [31:0] LOWER_RST = 32'h0000_8000;
  localparam logic [LIMIT_BITS-1:0] RUN_LIMIT_RST = '1;

  // Enable bit positions
  localparam int EN_TRACK    = 0;
  localparam int EN_UPPER    = 1;
  localparam int EN_LOWER    = 2;
  localparam int EN_TREND    = 3;
  localparam int EN_TRIGGER  = 4;
  localparam int EN_CROWDING = 5;

  // Alarm bit positions
  localparam int ALM_TREND    = 0;
  localparam int ALM_TRIGGER  = 1;
  localparam int ALM_CROWDING = 2;

  // Trend direction codes
  localparam logic [DIR_BITS-1:0] DIR_FLAT    = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_RISING  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_FALLING = 2'd2;

  typedef struct packed {
    logic [EN_BITS-1:0]    enable;
    logic [LIMIT_BITS-1:0] trend_limit;
    logic [LIMIT_BITS-1:0] trigger_limit;
    logic [LIMIT_BITS-1:0] crowding_limit;
  } cfg_t;

endpackage

/* hdl/spc_cfg.sv */
// APB configuration registers for the SPC statistics monitor.
module spc_cfg
  import spc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0]      cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0]      cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]      cfg_prdata,
  output logic                          cfg_pready,
  output cfg_t                          cfg,
  output logic signed [SAMPLE_BITS-1:0] upper_limit,
  output logic signed [SAMPLE_BITS-1:0] lower_limit
);

  cfg_t                          cfg_r;
  logic signed [SAMPLE_BITS-1:0] upper_r;
  logic signed [SAMPLE_BITS-1:0] lower_r;
  logic [REG_IDX_BITS-1:0]       idx;
  logic                          wr_en;

  assign idx        = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= '0;
      cfg_r.trend_limit    <= RUN_LIMIT_RST;
      cfg_r.trigger_limit  <= RUN_LIMIT_RST;
      cfg_r.crowding_limit <= RUN_LIMIT_RST;
      upper_r              <= UPPER_RST[SAMPLE_BITS-1:0];
      lower_r              <= LOWER_RST[SAMPLE_BITS-1:0];
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:   cfg_r.enable         <= cfg_pwdata[EN_BITS-1:0];
        REG_UPPER:    upper_r              <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_LOWER:    lower_r              <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_TREND:    cfg_r.trend_limit    <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_TRIGGER:  cfg_r.trigger_limit  <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_CROWDING: cfg_r.crowding_limit <= cfg_pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:   cfg_prdata = CFG_DATA_BITS'(cfg_r.enable);
      REG_UPPER:    cfg_prdata = CFG_DATA_BITS'(upper_r);
      REG_LOWER:    cfg_prdata = CFG_DATA_BITS'(lower_r);
      REG_TREND:    cfg_prdata = CFG_DATA_BITS'(cfg_r.trend_limit);
      REG_TRIGGER:  cfg_prdata = CFG_DATA_BITS'(cfg_r.trigger_limit);
      REG_CROWDING: cfg_prdata = CFG_DATA_BITS'(cfg_r.crowding_limit);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg         = cfg_r;
  assign upper_limit = upper_r;
  assign lower_limit = lower_r;

endmodule

/* hdl/spc_front.sv */
// Input register and squaring stage of the SPC statistics monitor.
module spc_front
  import spc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          in_beat,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          b_valid,
  output logic signed [SAMPLE_BITS-1:0] b_sample,
  output logic [SQ_BITS-1:0]            b_square
);

  logic                            a_valid_r;
  logic signed [SAMPLE_BITS-1:0]   a_sample_r;
  logic                            b_valid_r;
  logic signed [SAMPLE_BITS-1:0]   b_sample_r;
  logic [SQ_BITS-1:0]              b_square_r;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  // square is never negative, so widening is safe either way
  assign prod = a_sample_r * a_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_beat;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_sample_r <= in_sample;
      b_sample_r <= a_sample_r;
      b_square_r <= SQ_BITS'(prod);
    end
  end

  assign b_valid  = b_valid_r;
  assign b_sample = b_sample_r;
  assign b_square = b_square_r;

endmodule

/* hdl/spc_core.sv */
// Running statistics and SPC run-rule state, doubling as the result register.
module spc_core
  import spc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int RUN_BITS    = RUN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          update,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SQ_BITS-1:0]            square,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] upper_limit,
  input  logic signed [SAMPLE_BITS-1:0] lower_limit,
  output logic signed [SUM_BITS-1:0]    total,
  output logic [SQ_BITS-1:0]            total_squares,
  output logic signed [SAMPLE_BITS-1:0] smallest,
  output logic signed [SAMPLE_BITS-1:0] largest,
  output logic [COUNT_BITS-1:0]         sample_count,
  output logic [RUN_BITS-1:0]           trend_run,
  output logic [DIR_BITS-1:0]           trend_dir,
  output logic [RUN_BITS-1:0]           trigger_run,
  output logic [RUN_BITS-1:0]           crowding_run,
  output logic [ALARM_BITS-1:0]         alarms
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [RUN_BITS-1:0]   RUN_MAX = '1;
  localparam int CMP_W = (RUN_BITS > LIMIT_BITS) ? RUN_BITS : LIMIT_BITS;

  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [SQ_BITS-1:0]            sq_r, sq_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic                          rise_r, rise_nxt;
  logic                          fall_r, fall_nxt;
  logic [RUN_BITS-1:0]           trend_r, trend_nxt;
  logic [RUN_BITS-1:0]           trig_r, trig_nxt;
  logic [RUN_BITS-1:0]           crowd_r, crowd_nxt;
  logic [ALARM_BITS-1:0]         alarms_r, alarms_nxt;
  logic                          sat;
  logic                          outside;
  logic                          up_en, lo_en;

  function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] c);
    return (c == RUN_MAX) ? c : c + RUN_BITS'(1);
  endfunction

  assign sat     = (count_r == CNT_MAX);
  assign up_en   = cfg.enable[EN_UPPER];
  assign lo_en   = cfg.enable[EN_LOWER];
  assign outside = (up_en && sample >= upper_limit) || (lo_en && sample <= lower_limit);

  always_comb begin
    sum_nxt   = sat ? sum_r : sum_r + SUM_BITS'(sample);
    sq_nxt    = sat ? sq_r : sq_r + square;
    count_nxt = sat ? count_r : count_r + COUNT_BITS'(1);

    min_nxt = min_r;
    max_nxt = max_r;
    if (count_r == '0) begin
      min_nxt = sample;
      max_nxt = sample;
    end else if (sample > max_r) begin
      max_nxt = sample;
    end else if (sample < min_r) begin
      min_nxt = sample;
    end

    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    trend_nxt  = trend_r;
    trig_nxt   = trig_r;
    crowd_nxt  = crowd_r;
    alarms_nxt = '0;
    if (cfg.enable[EN_TRACK]) begin
      if (sample > prev_r) begin
        trend_nxt = rise_r ? run_inc(trend_r) : '0;
        rise_nxt  = 1'b1;
        fall_nxt  = 1'b0;
      end else if (sample < prev_r) begin
        trend_nxt = fall_r ? run_inc(trend_r) : '0;
        rise_nxt  = 1'b0;
        fall_nxt  = 1'b1;
      end else begin
        trend_nxt = '0;
        rise_nxt  = 1'b0;
        fall_nxt  = 1'b0;
      end

      if (outside) begin
        trig_nxt  = run_inc(trig_r);
        crowd_nxt = '0;
      end else if (up_en && lo_en) begin
        crowd_nxt = run_inc(crowd_r);
        trig_nxt  = '0;
      end else begin
        trig_nxt  = '0;
        crowd_nxt = '0;
      end

      alarms_nxt[ALM_TREND] = cfg.enable[EN_TREND] &&
                              (CMP_W'(trend_nxt) > CMP_W'(cfg.trend_limit));
      alarms_nxt[ALM_TRIGGER] = cfg.enable[EN_TRIGGER] &&
                                (CMP_W'(trig_nxt) > CMP_W'(cfg.trigger_limit));
      alarms_nxt[ALM_CROWDING] = cfg.enable[EN_CROWDING] &&
                                 (CMP_W'(crowd_nxt) > CMP_W'(cfg.crowding_limit));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      sq_r     <= '0;
      min_r    <= '0;
      max_r    <= '0;
      count_r  <= '0;
      prev_r   <= '0;
      rise_r   <= 1'b0;
      fall_r   <= 1'b0;
      trend_r  <= '0;
      trig_r   <= '0;
      crowd_r  <= '0;
      alarms_r <= '0;
    end else if (update) begin
      sum_r    <= sum_nxt;
      sq_r     <= sq_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      count_r  <= count_nxt;
      prev_r   <= sample;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      trend_r  <= trend_nxt;
      trig_r   <= trig_nxt;
      crowd_r  <= crowd_nxt;
      alarms_r <= alarms_nxt;
    end
  end

  assign total         = sum_r;
  assign total_squares = sq_r;
  assign smallest      = min_r;
  assign largest       = max_r;
  assign sample_count  = count_r;
  assign trend_run     = trend_r;
  assign trend_dir     = rise_r ? DIR_RISING : (fall_r ? DIR_FALLING : DIR_FLAT);
  assign trigger_run   = trig_r;
  assign crowding_run  = crowd_r;
  assign alarms        = alarms_r;

  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rise_r && fall_r))
    else $error("trend direction both rising and falling");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(trig_r != '0 && crowd_r != '0))
    else $error("trigger and crowding runs both active");

  a_count_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    sat |=> (count_r == CNT_MAX))
    else $error("saturated sample count moved");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sat |=> ($stable(sum_r) && $stable(sq_r)))
    else $error("accumulators changed after count saturation");

endmodule

/* hdl/spc_running_stats_monitor.sv */
// Top level of the SPC running statistics monitor.
//
// One signed sample enters per in_ beat; each sample produces exactly one
// out_ beat carrying the running sum, sum of squares, extremes, sample count,
// the three SPC run counters, trend direction and the alarm bits.
// Settings are written over the APB-style cfg_ port; the user must do so only
// while the stream is idle, which the block itself does not enforce.
// Each accepted in_ beat passes the input register, squaring register and
// statistics/result register in turn before out_tvalid rises.
// Throughput: one sample per cycle; the accumulators close their loop in the
// last stage, one add and compare per cycle, with the multiply a stage ahead.
// When a result is waiting and out_tready is low, the whole pipe holds and
// in_tready drops; with no result waiting the pipe moves on whatever
// out_tready does.
// Reset (rst_n low, synchronous) clears all statistics, empties the pipe and
// returns the settings to their defaults: tracking off, limits wide open.
module spc_running_stats_monitor
  import spc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int RUN_BITS    = RUN_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int RAW_W = SUM_BITS + SQ_BITS + 2 * SAMPLE_BITS + COUNT_BITS
                         + 3 * RUN_BITS + DIR_BITS + ALARM_BITS,
  localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata: sample
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,
  // out_tdata: total, total_squares, smallest, largest, sample_count,
  //            trend_run, trend_dir, trigger_run, crowding_run, alarms
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_W-1:0]         out_tdata,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t                          cfg;
  logic signed [SAMPLE_BITS-1:0] upper_limit;
  logic signed [SAMPLE_BITS-1:0] lower_limit;
  logic                          advance;
  logic                          b_valid;
  logic signed [SAMPLE_BITS-1:0] b_sample;
  logic [SQ_BITS-1:0]            b_square;
  logic                          out_valid_r;

  logic signed [SUM_BITS-1:0]    total;
  logic [SQ_BITS-1:0]            total_squares;
  logic signed [SAMPLE_BITS-1:0] smallest;
  logic signed [SAMPLE_BITS-1:0] largest;
  logic [COUNT_BITS-1:0]         sample_count;
  logic [RUN_BITS-1:0]           trend_run;
  logic [DIR_BITS-1:0]           trend_dir;
  logic [RUN_BITS-1:0]           trigger_run;
  logic [RUN_BITS-1:0]           crowding_run;
  logic [ALARM_BITS-1:0]         alarms;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  spc_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg),
    .upper_limit(upper_limit),
    .lower_limit(lower_limit)
  );

  spc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_beat  (in_tvalid && in_tready),
    .in_sample(in_tdata[SAMPLE_BITS-1:0]),
    .b_valid  (b_valid),
    .b_sample (b_sample),
    .b_square (b_square)
  );

  spc_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .RUN_BITS   (RUN_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .update       (advance && b_valid),
    .sample       (b_sample),
    .square       (b_square),
    .cfg          (cfg),
    .upper_limit  (upper_limit),
    .lower_limit  (lower_limit),
    .total        (total),
    .total_squares(total_squares),
    .smallest     (smallest),
    .largest      (largest),
    .sample_count (sample_count),
    .trend_run    (trend_run),
    .trend_dir    (trend_dir),
    .trigger_run  (trigger_run),
    .crowding_run (crowding_run),
    .alarms       (alarms)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata            = '0;
    out_tdata[RAW_W-1:0] = {alarms, crowding_run, trigger_run, trend_dir, trend_run,
                            sample_count, largest, smallest, total_squares, total};
  end

endmodule
